// ===== hdl/alubs_pkg.sv =====
// ----------------------------------------------------------------------------
// alubs_pkg
// Shared types, codes and helpers for the data-processing execute unit.
// ----------------------------------------------------------------------------
package alubs_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned REG_W  = 4;
   localparam int unsigned FLAG_W = 4;
   localparam int unsigned RS_W   = 8;

   localparam logic [REG_W-1:0] REG_PC = 4'hF;

   // flag bit positions
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   typedef enum logic [3:0] {
      OP_AND = 4'h0,
      OP_EOR = 4'h1,
      OP_SUB = 4'h2,
      OP_RSB = 4'h3,
      OP_ADD = 4'h4,
      OP_ADC = 4'h5,
      OP_SBC = 4'h6,
      OP_RSC = 4'h7,
      OP_TST = 4'h8,
      OP_TEQ = 4'h9,
      OP_CMP = 4'hA,
      OP_CMN = 4'hB,
      OP_ORR = 4'hC,
      OP_MOV = 4'hD,
      OP_BIC = 4'hE,
      OP_MVN = 4'hF
   } opcode_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] instr_word;
      logic [WORD_W-1:0] rn_value;
      logic [WORD_W-1:0] rm_value;
      logic [RS_W-1:0]   rs_low_byte;
      logic [FLAG_W-1:0] flags_in;
      logic              has_spsr;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic [REG_W-1:0]  dest_index;
      logic              write_result;
      logic [FLAG_W-1:0] flags_out;
      logic              flags_write;
      logic              restore_spsr;
   } rsp_type;

   function automatic logic [WORD_W-1:0] ror_word(input logic [WORD_W-1:0] v,
                                                  input logic [4:0]        n);
      logic [2*WORD_W-1:0] d;
      d = {v, v} >> n;
      return d[WORD_W-1:0];
   endfunction

endpackage

// ===== hdl/alubs_shifter.sv =====
// ----------------------------------------------------------------------------
// alubs_shifter
// Barrel shifter: forms the second operand and the shifter carry-out.
// ----------------------------------------------------------------------------
module alubs_shifter (
   input  logic [alubs_pkg::WORD_W-1:0] instr_word,
   input  logic [alubs_pkg::WORD_W-1:0] rm_value,
   input  logic [alubs_pkg::RS_W-1:0]   rs_low_byte,
   input  logic                         carry_in,
   output logic [alubs_pkg::WORD_W-1:0] operand,
   output logic                         carry_out
);
   import alubs_pkg::*;

   shift_kind_type    kind;
   logic [4:0]        rot;
   logic [WORD_W-1:0] imm_val;
   logic [WORD_W-1:0] rm_reg;
   logic [4:0]        sh_imm;
   logic [RS_W-1:0]   sh_reg;
   logic [WORD_W:0]   lsl_r, lsr_r, asr_r, lsl_i, lsr_i, asr_i;
   logic [WORD_W-1:0] ror_r, ror_i;

   always_comb begin
      kind    = shift_kind_type'(instr_word[6:5]);
      rot     = {instr_word[11:8], 1'b0};
      imm_val = ror_word({24'd0, instr_word[7:0]}, rot);
      rm_reg  = (instr_word[3:0] == REG_PC) ? rm_value + 32'd4 : rm_value;
      sh_imm  = instr_word[11:7];
      sh_reg  = rs_low_byte;

      // 33-bit forms keep the last bit shifted out next to the result
      lsl_r = {1'b0, rm_reg} << sh_reg[4:0];
      lsr_r = {rm_reg, 1'b0} >> sh_reg[4:0];
      asr_r = (WORD_W+1)'($signed({rm_reg, 1'b0}) >>> sh_reg[4:0]);
      ror_r = ror_word(rm_reg, sh_reg[4:0]);
      lsl_i = {1'b0, rm_value} << sh_imm;
      lsr_i = {rm_value, 1'b0} >> sh_imm;
      asr_i = (WORD_W+1)'($signed({rm_value, 1'b0}) >>> sh_imm);
      ror_i = ror_word(rm_value, sh_imm);

      operand   = rm_value;
      carry_out = carry_in;
      if (instr_word[25]) begin
         operand   = imm_val;
         carry_out = (rot != 5'd0) ? imm_val[31] : carry_in;
      end else if (instr_word[4]) begin
         if (sh_reg == 8'd0) begin
            operand   = rm_reg;
            carry_out = carry_in;
         end else begin
            case (kind)
               SH_LSL: begin
                  if (sh_reg < 8'd32) begin
                     operand   = lsl_r[WORD_W-1:0];
                     carry_out = lsl_r[WORD_W];
                  end else begin
                     operand   = '0;
                     carry_out = (sh_reg == 8'd32) ? rm_reg[0] : 1'b0;
                  end
               end
               SH_LSR: begin
                  if (sh_reg < 8'd32) begin
                     operand   = lsr_r[WORD_W:1];
                     carry_out = lsr_r[0];
                  end else begin
                     operand   = '0;
                     carry_out = (sh_reg == 8'd32) ? rm_reg[31] : 1'b0;
                  end
               end
               SH_ASR: begin
                  if (sh_reg < 8'd32) begin
                     operand   = asr_r[WORD_W:1];
                     carry_out = asr_r[0];
                  end else begin
                     operand   = {WORD_W{rm_reg[31]}};
                     carry_out = rm_reg[31];
                  end
               end
               default: begin
                  operand   = ror_r;
                  carry_out = ror_r[31];
               end
            endcase
         end
      end else begin
         case (kind)
            SH_LSL: begin
               if (sh_imm == 5'd0) begin
                  operand   = rm_value;
                  carry_out = carry_in;
               end else begin
                  operand   = lsl_i[WORD_W-1:0];
                  carry_out = lsl_i[WORD_W];
               end
            end
            SH_LSR: begin
               if (sh_imm == 5'd0) begin
                  operand   = '0;
                  carry_out = rm_value[31];
               end else begin
                  operand   = lsr_i[WORD_W:1];
                  carry_out = lsr_i[0];
               end
            end
            SH_ASR: begin
               if (sh_imm == 5'd0) begin
                  operand   = {WORD_W{rm_value[31]}};
                  carry_out = rm_value[31];
               end else begin
                  operand   = asr_i[WORD_W:1];
                  carry_out = asr_i[0];
               end
            end
            default: begin
               if (sh_imm == 5'd0) begin
                  // rotate right extended through carry
                  operand   = {carry_in, rm_value[31:1]};
                  carry_out = rm_value[0];
               end else begin
                  operand   = ror_i;
                  carry_out = ror_i[31];
               end
            end
         endcase
      end
   end

endmodule

// ===== hdl/alubs_alu.sv =====
// ----------------------------------------------------------------------------
// alubs_alu
// Opcode execution, flag generation and write-back control.
// ----------------------------------------------------------------------------
module alubs_alu (
   input  alubs_pkg::req_type           req,
   input  logic [alubs_pkg::WORD_W-1:0] operand,
   input  logic                         shift_carry,
   output alubs_pkg::rsp_type           rsp
);
   import alubs_pkg::*;

   opcode_type        opc;
   logic              s_bit;
   logic [REG_W-1:0]  rd;
   logic              c_in;
   logic              is_cmp;
   logic              arith;
   logic [WORD_W-1:0] add_a, add_b, res, logic_res;
   logic              add_c;
   logic [WORD_W:0]   sum;
   logic              c_new, v_new;

   always_comb begin
      opc    = opcode_type'(req.instr_word[24:21]);
      s_bit  = req.instr_word[20];
      rd     = req.instr_word[15:12];
      c_in   = req.flags_in[FLAG_C];
      is_cmp = opc inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};

      // select adder operands; one shared adder serves all arithmetic
      arith = 1'b1;
      add_a = req.rn_value;
      add_b = operand;
      add_c = 1'b0;
      case (opc)
         OP_SUB, OP_CMP: begin add_b = ~operand; add_c = 1'b1; end
         OP_RSB:         begin add_a = operand; add_b = ~req.rn_value; add_c = 1'b1; end
         OP_ADD, OP_CMN: begin add_c = 1'b0; end
         OP_ADC:         begin add_c = c_in; end
         OP_SBC:         begin add_b = ~operand; add_c = c_in; end
         OP_RSC:         begin add_a = operand; add_b = ~req.rn_value; add_c = c_in; end
         default:        arith = 1'b0;
      endcase

      sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_c};

      case (opc)
         OP_AND, OP_TST: logic_res = req.rn_value & operand;
         OP_EOR, OP_TEQ: logic_res = req.rn_value ^ operand;
         OP_ORR:         logic_res = req.rn_value | operand;
         OP_MOV:         logic_res = operand;
         OP_BIC:         logic_res = req.rn_value & ~operand;
         default:        logic_res = ~operand;
      endcase

      res   = arith ? sum[WORD_W-1:0] : logic_res;
      c_new = arith ? sum[WORD_W] : shift_carry;
      v_new = arith ? ((add_a[31] ^ res[31]) & (add_b[31] ^ res[31]))
                    : req.flags_in[FLAG_V];

      rsp.result       = res;
      rsp.dest_index   = rd;
      rsp.write_result = ~is_cmp;
      rsp.flags_out    = req.flags_in;
      rsp.flags_write  = 1'b0;
      rsp.restore_spsr = 1'b0;
      if (is_cmp || (s_bit && (rd != REG_PC))) begin
         rsp.flags_out   = {res[31], (res == '0), c_new, v_new};
         rsp.flags_write = 1'b1;
      end else if (s_bit && req.has_spsr) begin
         rsp.restore_spsr = 1'b1;
      end
   end

endmodule

// ===== hdl/alu_barrel_shifter_flags_top.sv =====
// ----------------------------------------------------------------------------
// alu_barrel_shifter_flags_top
// Data-processing execute unit: barrel shifter, ALU and NZCV flag logic.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  instr, rn, rm, rs low byte, flags, has_spsr
//  rsp      out        rsp_valid / rsp_ready  result, rd, write, flags, flag write, restore
//
//  From request to response a transaction passes an input register, then
//  shifter and ALU in one pass into the result register.
//  One transaction is accepted every cycle while the response side keeps up.
//  A stalled response holds the result register; the input register still
//  fills, so one more transaction is taken before req_ready drops.
//  Synchronous active-high reset empties both stages.
//
module alu_barrel_shifter_flags_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [alubs_pkg::WORD_W-1:0] req_instr_word,
   input  logic [alubs_pkg::WORD_W-1:0] req_rn_value,
   input  logic [alubs_pkg::WORD_W-1:0] req_rm_value,
   input  logic [alubs_pkg::RS_W-1:0]   req_rs_low_byte,
   input  logic [alubs_pkg::FLAG_W-1:0] req_flags_in,
   input  logic                         req_has_spsr,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [alubs_pkg::WORD_W-1:0] rsp_result,
   output logic [alubs_pkg::REG_W-1:0]  rsp_dest_index,
   output logic                         rsp_write_result,
   output logic [alubs_pkg::FLAG_W-1:0] rsp_flags_out,
   output logic                         rsp_flags_write,
   output logic                         rsp_restore_spsr
);
   import alubs_pkg::*;

   req_type           stage_ff, stage_in;
   logic              stage_valid_ff, stage_valid_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic              advance;
   logic [WORD_W-1:0] operand;
   logic              shift_carry;
   rsp_type           alu_rsp;

   // Advance the input stage when the result register is free or draining.
   assign advance   = ~out_valid_ff | rsp_ready;
   assign req_ready = ~stage_valid_ff | advance;

   alubs_shifter u_shifter (
      .instr_word  (stage_ff.instr_word),
      .rm_value    (stage_ff.rm_value),
      .rs_low_byte (stage_ff.rs_low_byte),
      .carry_in    (stage_ff.flags_in[FLAG_C]),
      .operand     (operand),
      .carry_out   (shift_carry)
   );

   alubs_alu u_alu (
      .req         (stage_ff),
      .operand     (operand),
      .shift_carry (shift_carry),
      .rsp         (alu_rsp)
   );

   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff;

      // Capture a new transaction whenever the input stage can take one.
      if (req_ready) begin
         stage_valid_in        = req_valid;
         stage_in.instr_word   = req_instr_word;
         stage_in.rn_value     = req_rn_value;
         stage_in.rm_value     = req_rm_value;
         stage_in.rs_low_byte  = req_rs_low_byte;
         stage_in.flags_in     = req_flags_in;
         stage_in.has_spsr     = req_has_spsr;
      end

      // Move the executed result forward; otherwise hold it.
      if (advance) begin
         out_valid_in = stage_valid_ff;
         out_in       = alu_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result       = out_ff.result;
   assign rsp_dest_index   = out_ff.dest_index;
   assign rsp_write_result = out_ff.write_result;
   assign rsp_flags_out    = out_ff.flags_out;
   assign rsp_flags_write  = out_ff.flags_write;
   assign rsp_restore_spsr = out_ff.restore_spsr;

endmodule

// ===== hdl/alubs_checker.sv =====
// ----------------------------------------------------------------------------
// alubs_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module alubs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [alubs_pkg::WORD_W-1:0] rsp_result,
   input logic [alubs_pkg::REG_W-1:0]  rsp_dest_index,
   input logic                         rsp_write_result,
   input logic [alubs_pkg::FLAG_W-1:0] rsp_flags_out,
   input logic                         rsp_flags_write,
   input logic                         rsp_restore_spsr
);
   import alubs_pkg::*;

   // stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_flags_out))
      else $error("response changed while stalled");

   // a restore is only for a written PC with no flag update
   a_restore: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restore_spsr |->
         rsp_dest_index == REG_PC && rsp_write_result && !rsp_flags_write)
      else $error("restore request with inconsistent controls");

   // compares never write back and always set flags
   a_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_result |-> rsp_flags_write && !rsp_restore_spsr)
      else $error("compare without flag update");

   // new N and Z follow the result
   a_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flags_write |->
         rsp_flags_out[FLAG_N] == rsp_result[31]
         && rsp_flags_out[FLAG_Z] == (rsp_result == '0))
      else $error("N or Z flag does not match result");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind alu_barrel_shifter_flags_top alubs_checker u_alubs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result       (rsp_result),
   .rsp_dest_index   (rsp_dest_index),
   .rsp_write_result (rsp_write_result),
   .rsp_flags_out    (rsp_flags_out),
   .rsp_flags_write  (rsp_flags_write),
   .rsp_restore_spsr (rsp_restore_spsr)
);
